// ----- design/bdq_pkg.sv -----
// shared types and constants for the bounded deque unit
// no dependencies
package bdq_pkg;

  localparam int DEPTH  = 16;
  localparam int DATA_W = 32;
  localparam int IDX_W  = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int MODE_W = 3;

  // operation codes
  localparam logic [MODE_W-1:0] OP_PUSH_FRONT = 3'd0;
  localparam logic [MODE_W-1:0] OP_PUSH_BACK  = 3'd1;
  localparam logic [MODE_W-1:0] OP_POP_FRONT  = 3'd2;
  localparam logic [MODE_W-1:0] OP_POP_BACK   = 3'd3;
  localparam logic [MODE_W-1:0] OP_REMOVE     = 3'd4;
  localparam logic [MODE_W-1:0] OP_REVERSE    = 3'd5;
  localparam logic [MODE_W-1:0] OP_CLEAR      = 3'd6;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [DATA_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic [CNT_W-1:0]  count;
    logic [DATA_W-1:0] front_value;
    logic [DATA_W-1:0] back_value;
    logic              is_empty;
    logic              found;
    logic              overflow;
  } rsp_t;

  // top level to sequencer
  typedef struct packed {
    logic start;
    logic out_free;
  } seq_ctl_t;

  // sequencer to top level
  typedef struct packed {
    logic idle;
    logic done;
  } seq_stat_t;

endpackage

// ----- design/bdq_store.sv -----
// slot memory of the deque: one write port, one read port with registered data
// depends on bdq_pkg
module bdq_store
  import bdq_pkg::*;
(
  input  logic              clk,
  input  logic              we,
  input  logic [IDX_W-1:0]  waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic [IDX_W-1:0]  raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ----- design/bdq_seq.sv -----
// sequencer of the deque: pointer state, search-and-shift loop, front/back readout
// depends on bdq_pkg and bdq_store
module bdq_seq
  import bdq_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  seq_ctl_t  ctl,
  input  req_t      req,
  output seq_stat_t stat,
  output rsp_t      result
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_SHIFT = 3'd2;
  localparam logic [2:0] S_RDF   = 3'd3;
  localparam logic [2:0] S_RDB   = 3'd4;
  localparam logic [2:0] S_RDK   = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  localparam logic [IDX_W:0]   DEPTH_X   = (IDX_W + 1)'(DEPTH);
  localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);
  localparam logic [CNT_W-1:0] ONE       = CNT_W'(1);
  localparam logic [CNT_W-1:0] TWO       = CNT_W'(2);

  logic [2:0]        state, state_next;
  logic [DATA_W-1:0] value, value_next;
  logic [IDX_W-1:0]  start_idx, start_idx_next;
  logic [CNT_W-1:0]  count, count_next;
  logic              flipped, flipped_next;
  logic [CNT_W-1:0]  pos, pos_next;
  logic              found, found_next;
  logic              overflow, overflow_next;
  logic [DATA_W-1:0] front, front_next;
  logic [DATA_W-1:0] back, back_next;

  logic              we;
  logic [IDX_W-1:0]  waddr;
  logic [DATA_W-1:0] wdata;
  logic [IDX_W-1:0]  raddr;
  logic [DATA_W-1:0] rdata;
  logic              prepend;

  function automatic logic [IDX_W-1:0] wrap_add(input logic [IDX_W-1:0] a,
                                                 input logic [IDX_W-1:0] b);
    logic [IDX_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= DEPTH_X) begin
      s = s - DEPTH_X;
    end
    return s[IDX_W-1:0];
  endfunction

  // physical slot of a logical position
  function automatic logic [IDX_W-1:0] phys_of(input logic [CNT_W-1:0] p,
                                                input logic [IDX_W-1:0] st,
                                                input logic [CNT_W-1:0] cnt,
                                                input logic             flp);
    logic [CNT_W-1:0] off;
    off = flp ? (cnt - ONE - p) : p;
    return wrap_add(st, off[IDX_W-1:0]);
  endfunction

  bdq_store u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_comb begin
    state_next     = state;
    value_next     = value;
    start_idx_next = start_idx;
    count_next     = count;
    flipped_next   = flipped;
    pos_next       = pos;
    found_next     = found;
    overflow_next  = overflow;
    front_next     = front;
    back_next      = back;
    we             = 1'b0;
    waddr          = '0;
    wdata          = value;
    raddr          = '0;
    prepend        = (req.mode == OP_PUSH_FRONT) != flipped;

    unique case (state)
      S_IDLE: begin
        if (ctl.start) begin
          value_next    = req.value;
          found_next    = 1'b0;
          overflow_next = 1'b0;
          state_next    = S_RDF;
          unique case (req.mode)
            OP_PUSH_FRONT, OP_PUSH_BACK: begin
              if (count == DEPTH_CNT) begin
                overflow_next = 1'b1;
              end else begin
                we         = 1'b1;
                wdata      = req.value;
                count_next = count + ONE;
                if (prepend) begin
                  start_idx_next = (start_idx == '0) ? LAST_IDX : start_idx - IDX_W'(1);
                  waddr          = start_idx_next;
                end else begin
                  waddr = wrap_add(start_idx, count[IDX_W-1:0]);
                end
              end
            end
            OP_POP_FRONT, OP_POP_BACK: begin
              if (count != '0) begin
                count_next = count - ONE;
                // dropping the physical first entry moves the start
                if ((req.mode == OP_POP_FRONT) != flipped) begin
                  start_idx_next = wrap_add(start_idx, IDX_W'(1));
                end
              end
            end
            OP_REMOVE: begin
              if (count != '0) begin
                raddr      = phys_of('0, start_idx, count, flipped);
                pos_next   = '0;
                state_next = S_SCAN;
              end
            end
            OP_REVERSE: begin
              if (count >= TWO) begin
                flipped_next = !flipped;
              end
            end
            OP_CLEAR: begin
              count_next     = '0;
              start_idx_next = '0;
              flipped_next   = 1'b0;
            end
            default: begin
            end
          endcase
        end
      end
      S_SCAN: begin
        if (rdata == value) begin
          found_next = 1'b1;
          if (pos + ONE < count) begin
            raddr      = phys_of(pos + ONE, start_idx, count, flipped);
            state_next = S_SHIFT;
          end else begin
            count_next = count - ONE;
            if (flipped) begin
              start_idx_next = wrap_add(start_idx, IDX_W'(1));
            end
            state_next = S_RDF;
          end
        end else if (pos + ONE < count) begin
          raddr    = phys_of(pos + ONE, start_idx, count, flipped);
          pos_next = pos + ONE;
        end else begin
          state_next = S_RDF;
        end
      end
      S_SHIFT: begin
        // move the next entry one place toward the front
        we       = 1'b1;
        waddr    = phys_of(pos, start_idx, count, flipped);
        wdata    = rdata;
        pos_next = pos + ONE;
        if (pos + TWO < count) begin
          raddr = phys_of(pos + TWO, start_idx, count, flipped);
        end else begin
          count_next = count - ONE;
          if (flipped) begin
            start_idx_next = wrap_add(start_idx, IDX_W'(1));
          end
          state_next = S_RDF;
        end
      end
      S_RDF: begin
        if (count == '0) begin
          front_next = '0;
          back_next  = '0;
          state_next = S_DONE;
        end else begin
          raddr      = phys_of('0, start_idx, count, flipped);
          state_next = S_RDB;
        end
      end
      S_RDB: begin
        front_next = rdata;
        raddr      = phys_of(count - ONE, start_idx, count, flipped);
        state_next = S_RDK;
      end
      S_RDK: begin
        back_next  = rdata;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (ctl.out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      start_idx <= '0;
      count     <= '0;
      flipped   <= 1'b0;
    end else begin
      state     <= state_next;
      start_idx <= start_idx_next;
      count     <= count_next;
      flipped   <= flipped_next;
    end
    value    <= value_next;
    pos      <= pos_next;
    found    <= found_next;
    overflow <= overflow_next;
    front    <= front_next;
    back     <= back_next;
  end

  assign stat.idle = (state == S_IDLE);
  assign stat.done = (state == S_DONE);

  assign result.count       = count;
  assign result.front_value = front;
  assign result.back_value  = back;
  assign result.is_empty    = (count == '0);
  assign result.found       = found;
  assign result.overflow    = overflow;

endmodule

// ----- design/bounded_deque_with_search_remove_unit.sv -----
// bounded deque with search-and-remove; depends on bdq_pkg and bdq_seq
// an accepted request passes through the front read, back read and done states to the result register;
// an empty deque skips the reads. Remove adds a scan step per entry searched and a shift step per entry moved
// (scan and shift share the one slot read port). One request in flight: the request channel reopens the cycle
// after the result is registered, so no new request is taken before the last result is registered
// rst (synchronous) empties the deque and clears the order flag; slot data is not reset
module bounded_deque_with_search_remove_unit
  import bdq_pkg::*;
(
  input  logic clk,
  input  logic rst,
  // request channel
  input  logic req_valid,
  output logic req_stall,
  input  req_t req,
  // result channel
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp
);

  seq_ctl_t  ctl;
  seq_stat_t stat;
  rsp_t      result;
  logic      out_free;
  logic      load;

  // output register is free when empty or being taken this cycle
  assign out_free = !rsp_valid || !rsp_stall;
  // hand the finished result to the output register
  assign load     = stat.done && out_free;

  // requests are taken only while the sequencer waits for work
  assign req_stall    = !stat.idle;
  assign ctl.start    = req_valid && stat.idle;
  assign ctl.out_free = out_free;

  bdq_seq u_seq (
    .clk    (clk),
    .rst    (rst),
    .ctl    (ctl),
    .req    (req),
    .stat   (stat),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (load) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  // result payload holds while stalled
  always_ff @(posedge clk) begin
    if (load) begin
      rsp <= result;
    end
  end

endmodule

// ----- sim/testbench.sv -----
// testbench for bounded_deque_with_search_remove_unit: directed table, then random requests
// checked against a cycle-free shadow deque; depends on bdq_pkg and the unit's rtl
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import bdq_pkg::*;

  // mode code seven has no operation behind it, the unit must leave the deque alone
  localparam logic [MODE_W-1:0] OP_UNUSED = 3'd7;

  localparam int CLK_HALF      = 10;
  localparam int CYCLE_LIMIT   = 500000;
  localparam int PER_PHASE     = 310;
  localparam int SWING_LEN     = 40;
  localparam int DRAIN_CYCLES  = DEPTH + 24;
  localparam int HOLD_CYCLES   = 300;

  localparam rsp_t EMPTY_STATUS = '{5'd0, 32'h0, 32'h0, 1'b1, 1'b0, 1'b0};
  localparam rsp_t FULL_REFUSED = '{5'd16, 32'h8000000E, 32'h1, 1'b0, 1'b0, 1'b1};
  localparam rsp_t UNCHECKED    = '0;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_t rsp;

  bounded_deque_with_search_remove_unit dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  initial begin
    forever begin
      #(CLK_HALF) clk = ~clk;
    end
  end

  // idling knobs, changed by the request side between phases
  int idle_phase = 0;
  int send_idle_pct = 12;
  int rsp_stall_pct = 85;

  int mismatch_count = 0;
  int cycle_count = 0;

  // status words still owed by the unit, oldest first
  rsp_t pending_status[$];

  // ---------------------------------------------------------------------------
  // shadow deque: circular store, start slot, entry count and order flag
  // ---------------------------------------------------------------------------
  logic [DATA_W-1:0] shadow_slot [DEPTH];
  logic [IDX_W-1:0]  shadow_start = '0;
  logic [CNT_W-1:0]  shadow_count = '0;
  logic              shadow_flipped = 1'b0;

  function automatic logic [IDX_W-1:0] wrap_slot(int unsigned base, int unsigned off);
    return IDX_W'((base + off) % DEPTH);
  endfunction

  // physical slot of a logical position, honoring the order flag
  function automatic logic [IDX_W-1:0] slot_at(int unsigned pos);
    int unsigned off;
    off = shadow_flipped ? (int'(shadow_count) - 1 - pos) : pos;
    return wrap_slot(shadow_start, off);
  endfunction

  function automatic void store_ahead(logic [DATA_W-1:0] v);
    shadow_start = (shadow_start == '0) ? IDX_W'(DEPTH - 1) : shadow_start - 1'b1;
    shadow_slot[shadow_start] = v;
    shadow_count++;
  endfunction

  function automatic void store_behind(logic [DATA_W-1:0] v);
    shadow_slot[wrap_slot(shadow_start, shadow_count)] = v;
    shadow_count++;
  endfunction

  function automatic void drop_ahead();
    shadow_start = wrap_slot(shadow_start, 1);
    shadow_count--;
  endfunction

  // close the gap left by the entry at a logical position, toward the front
  function automatic void erase_at(int unsigned pos);
    for (int unsigned i = pos; i + 1 < shadow_count; i++) begin
      shadow_slot[slot_at(i)] = shadow_slot[slot_at(i + 1)];
    end
    if (shadow_flipped) begin
      drop_ahead();
    end else begin
      shadow_count--;
    end
  endfunction

  // apply one request to the shadow deque and return the status it must produce
  function automatic rsp_t deque_apply(req_t r);
    rsp_t s;
    bit   full;
    bit   hit;
    bit   refused;
    full = shadow_count >= DEPTH;
    hit = 1'b0;
    refused = 1'b0;
    case (r.mode)
      OP_PUSH_FRONT: begin
        if (full) refused = 1'b1;
        else if (shadow_flipped) store_behind(r.value);
        else store_ahead(r.value);
      end
      OP_PUSH_BACK: begin
        if (full) refused = 1'b1;
        else if (shadow_flipped) store_ahead(r.value);
        else store_behind(r.value);
      end
      OP_POP_FRONT: begin
        if (shadow_count != 0) begin
          if (shadow_flipped) shadow_count--;
          else drop_ahead();
        end
      end
      OP_POP_BACK: begin
        if (shadow_count != 0) begin
          if (shadow_flipped) drop_ahead();
          else shadow_count--;
        end
      end
      OP_REMOVE: begin
        // first match from the logical front wins
        for (int unsigned i = 0; i < shadow_count; i++) begin
          if (!hit && shadow_slot[slot_at(i)] == r.value) begin
            erase_at(i);
            hit = 1'b1;
          end
        end
      end
      OP_REVERSE: begin
        if (shadow_count >= 2) shadow_flipped = ~shadow_flipped;
      end
      OP_CLEAR: begin
        shadow_count = '0;
        shadow_start = '0;
        shadow_flipped = 1'b0;
      end
      default: begin
      end
    endcase
    s.count = shadow_count;
    s.is_empty = (shadow_count == 0);
    s.front_value = s.is_empty ? '0 : shadow_slot[slot_at(0)];
    s.back_value = s.is_empty ? '0 : shadow_slot[slot_at(shadow_count - 1)];
    s.found = hit;
    s.overflow = refused;
    return s;
  endfunction

  // ---------------------------------------------------------------------------
  // random requests
  // ---------------------------------------------------------------------------

  // removes mostly target a live entry so the scan and shift get exercised;
  // a small pool of values makes duplicates common, so first-match matters
  function automatic logic [DATA_W-1:0] pick_value(bit for_remove);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (for_remove && shadow_count != 0 && roll < 60) begin
      return shadow_slot[slot_at($urandom_range(0, int'(shadow_count) - 1))];
    end
    if (roll < 70) return DATA_W'($urandom_range(0, 7));
    if (roll < 78) begin
      case ($urandom_range(0, 3))
        0: return 32'h0000_0000;
        1: return 32'hFFFF_FFFF;
        2: return 32'h8000_0000;
        default: return 32'h7FFF_FFFF;
      endcase
    end
    return $urandom;
  endfunction

  // filling swings lean on pushes so the deque runs full and refuses pushes,
  // draining swings lean on pops so it runs dry and pops hit an empty deque
  function automatic req_t random_request(bit filling);
    req_t r;
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (filling) begin
      if (roll < 30)      r.mode = OP_PUSH_FRONT;
      else if (roll < 60) r.mode = OP_PUSH_BACK;
      else if (roll < 68) r.mode = OP_POP_FRONT;
      else if (roll < 76) r.mode = OP_POP_BACK;
      else if (roll < 90) r.mode = OP_REMOVE;
      else if (roll < 95) r.mode = OP_REVERSE;
      else if (roll < 97) r.mode = OP_CLEAR;
      else                r.mode = OP_UNUSED;
    end else begin
      if (roll < 12)      r.mode = OP_PUSH_FRONT;
      else if (roll < 25) r.mode = OP_PUSH_BACK;
      else if (roll < 47) r.mode = OP_POP_FRONT;
      else if (roll < 69) r.mode = OP_POP_BACK;
      else if (roll < 88) r.mode = OP_REMOVE;
      else if (roll < 94) r.mode = OP_REVERSE;
      else if (roll < 97) r.mode = OP_CLEAR;
      else                r.mode = OP_UNUSED;
    end
    r.value = pick_value(r.mode == OP_REMOVE);
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // directed table: value steps up by one on each repeat of a row;
  // typed rows carry their status, the rest go through the shadow deque
  // ---------------------------------------------------------------------------
  typedef struct {
    logic [MODE_W-1:0] mode;
    logic [DATA_W-1:0] value;
    int                reps;
    bit                typed;
    rsp_t              want;
  } script_row_t;

  localparam int SCRIPT_ROWS = 28;

  script_row_t script [SCRIPT_ROWS] = '{
    // everything on an empty deque leaves it empty
    '{OP_POP_FRONT,  32'h0000_0000, 1,  1'b1, EMPTY_STATUS},
    '{OP_POP_BACK,   32'hFFFF_FFFF, 1,  1'b1, EMPTY_STATUS},
    '{OP_REMOVE,     32'h0000_0000, 1,  1'b1, EMPTY_STATUS},
    '{OP_REVERSE,    32'h0000_0000, 1,  1'b1, EMPTY_STATUS},
    '{OP_UNUSED,     32'hFFFF_FFFF, 1,  1'b1, EMPTY_STATUS},
    // value extremes at both ends, then a real reverse
    '{OP_PUSH_BACK,  32'hFFFF_FFFF, 1,  1'b1,
      '{5'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0}},
    '{OP_PUSH_FRONT, 32'h0000_0000, 1,  1'b1,
      '{5'd2, 32'h0000_0000, 32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0}},
    '{OP_REVERSE,    32'h0000_0000, 1,  1'b1,
      '{5'd2, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0, 1'b0, 1'b0}},
    // pushes, pops and removes while the order is flipped
    '{OP_PUSH_FRONT, 32'hA5A5_A5A5, 1,  1'b0, UNCHECKED},
    '{OP_PUSH_BACK,  32'h5A5A_5A5A, 1,  1'b0, UNCHECKED},
    '{OP_REMOVE,     32'h0000_0000, 1,  1'b0, UNCHECKED},
    '{OP_REMOVE,     32'h1234_5678, 1,  1'b0, UNCHECKED},
    '{OP_UNUSED,     32'h0000_0000, 1,  1'b0, UNCHECKED},
    '{OP_POP_FRONT,  32'h0000_0000, 1,  1'b0, UNCHECKED},
    '{OP_POP_BACK,   32'h0000_0000, 1,  1'b0, UNCHECKED},
    '{OP_CLEAR,      32'h0000_0000, 1,  1'b1, EMPTY_STATUS},
    // reverse of a single entry changes nothing
    '{OP_PUSH_BACK,  32'h0000_0001, 1,  1'b0, UNCHECKED},
    '{OP_REVERSE,    32'h0000_0000, 1,  1'b0, UNCHECKED},
    // fill to the brim through the wrap of the start slot, then push into a full deque
    '{OP_PUSH_FRONT, 32'h8000_0000, 15, 1'b0, UNCHECKED},
    '{OP_PUSH_BACK,  32'h7FFF_FFFF, 1,  1'b1, FULL_REFUSED},
    '{OP_PUSH_FRONT, 32'h7FFF_FFFF, 1,  1'b1, FULL_REFUSED},
    // removes in the middle, at the back, and at both ends once flipped
    '{OP_REMOVE,     32'h8000_0007, 1,  1'b0, UNCHECKED},
    '{OP_REMOVE,     32'h0000_0001, 1,  1'b0, UNCHECKED},
    '{OP_REVERSE,    32'h0000_0000, 1,  1'b0, UNCHECKED},
    '{OP_REMOVE,     32'h8000_000E, 1,  1'b0, UNCHECKED},
    '{OP_REMOVE,     32'h8000_0000, 1,  1'b0, UNCHECKED},
    '{OP_PUSH_FRONT, 32'h5555_5555, 1,  1'b0, UNCHECKED},
    '{OP_CLEAR,      32'hFFFF_FFFF, 1,  1'b1, EMPTY_STATUS}
  };

  // ---------------------------------------------------------------------------
  // request side: drive at the falling edge, see acceptance at the rising edge
  // ---------------------------------------------------------------------------
  task automatic offer_request(input req_t r, input bit typed, input rsp_t want);
    rsp_t predicted;
    @(negedge clk);
    // random gap before the request; valid drops only while idling
    while ($urandom_range(0, 99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(negedge clk);
    end
    req_valid <= 1'b1;
    req <= r;
    do @(posedge clk); while (req_stall);
    predicted = deque_apply(r);
    pending_status.insert(pending_status.size(), typed ? want : predicted);
  endtask

  initial begin : request_side
    req_t r;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed part runs under the first idling pattern
    foreach (script[i]) begin
      for (int k = 0; k < script[i].reps; k++) begin
        r.mode = script[i].mode;
        r.value = script[i].value + DATA_W'(k);
        offer_request(r, script[i].typed, script[i].want);
      end
    end

    // random part: sender idles rarely, then often, then never
    for (int ph = 0; ph < 3; ph++) begin
      idle_phase = ph;
      send_idle_pct = (ph == 0) ? 12 : (ph == 1) ? 85 : 0;
      rsp_stall_pct = (ph == 0) ? 85 : (ph == 1) ? 12 : 0;
      for (int n = 0; n < PER_PHASE; n++) begin
        r = random_request(((n / SWING_LEN) % 2) == 0);
        offer_request(r, 1'b0, UNCHECKED);
      end
    end

    @(negedge clk);
    req_valid <= 1'b0;

    // let every owed status come back, then allow for a trailing remove scan
    while (pending_status.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // result side: random stall at the falling edge; once the last phase begins,
  // one long hold-off so the unit backs up and stalls its request channel
  // ---------------------------------------------------------------------------
  initial begin : result_side
    int hold_left;
    bit held_once;
    hold_left = 0;
    held_once = 1'b0;
    forever begin
      @(negedge clk);
      if (idle_phase == 2 && !held_once) begin
        held_once = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_stall <= 1'b1;
      end else begin
        rsp_stall <= ($urandom_range(0, 99) < rsp_stall_pct);
      end
    end
  end

  function automatic void check_field(string name, logic [DATA_W-1:0] want,
                                      logic [DATA_W-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      mismatch_count++;
    end
  endfunction

  // every accepted status is matched against the oldest one owed
  always @(posedge clk) begin : status_check
    rsp_t want;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (pending_status.size() == 0) begin
        $display("%0t: status with no request outstanding, expected none, actual %p",
                 $time, rsp);
        mismatch_count++;
      end else begin
        want = pending_status[0];
        pending_status.delete(0);
        check_field("count", DATA_W'(want.count), DATA_W'(rsp.count));
        check_field("front_value", want.front_value, rsp.front_value);
        check_field("back_value", want.back_value, rsp.back_value);
        check_field("is_empty", DATA_W'(want.is_empty), DATA_W'(rsp.is_empty));
        check_field("found", DATA_W'(want.found), DATA_W'(rsp.found));
        check_field("overflow", DATA_W'(want.overflow), DATA_W'(rsp.overflow));
      end
    end
  end

  // hang guard
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles, %0d status words still owed",
               $time, cycle_count, pending_status.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

endmodule
